// ----- rtl/ascii_cell_tone_glyph_select_defines.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASCII_CELL_TONE_GLYPH_SELECT_DEFINES_SVH
`define ASCII_CELL_TONE_GLYPH_SELECT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ACGS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ACGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/acgs_pkg.sv -----
package acgs_pkg;

  // Default largest pixel count of one cell.
  localparam int MAX_CELL_PIXELS_DEF = 4096;
  // Depth of the cell queue between the front and the back.
  localparam int CELL_Q_DEPTH = 4;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTRAST   = 4'd0,
    REG_BRIGHTNESS = 4'd1,
    REG_GAMMA      = 4'd2,
    REG_THRESHOLD  = 4'd3,
    REG_POSTERIZE  = 4'd4,
    REG_MODE       = 4'd5,
    REG_FG_BG      = 4'd6,
    REG_GRADIENT   = 4'd7
  } cfg_reg_t;

  // Reset values of the configuration registers.
  localparam logic [15:0] CONTRAST_RST   = 16'd4096;
  localparam logic [17:0] BRIGHTNESS_RST = 18'd0;
  localparam logic [15:0] GAMMA_RST      = 16'd4096;
  localparam logic [7:0]  THRESHOLD_RST  = 8'd0;
  localparam logic [7:0]  POSTERIZE_RST  = 8'd0;
  localparam logic [15:0] MODE_RST       = 16'h0900;
  localparam logic [63:0] FG_BG_RST      = 64'hFFFF_FFFF_0000_00FF;
  localparam logic [63:0] GRADIENT_RST   = 64'h0000_0000_0000_00FF;

  // Color mode codes in mode_flags bits 4..2.
  localparam logic [2:0] MODE_SOURCE   = 3'd0;
  localparam logic [2:0] MODE_TWO_TONE = 3'd1;
  localparam logic [2:0] MODE_GRADIENT = 3'd2;
  localparam logic [2:0] MODE_CUSTOM   = 3'd3;

  // Rec.709 luma weights scaled so that they sum to 65536.
  localparam logic [15:0] LUMA_KR = 16'd13933;
  localparam logic [15:0] LUMA_KG = 16'd46871;
  localparam logic [15:0] LUMA_KB = 16'd4732;

  localparam logic [16:0] ONE_Q16   = 17'h10000;
  localparam logic [16:0] HALF_Q16  = 17'h08000;
  localparam logic [15:0] GAMMA_MIN = 16'd5;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_in_cell;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  glyph_index;
    logic [15:0] adjusted_luma;
    logic [7:0]  ink_red;
    logic [7:0]  ink_green;
    logic [7:0]  ink_blue;
    logic [7:0]  ink_alpha;
    logic [7:0]  base_red;
    logic [7:0]  base_green;
    logic [7:0]  base_blue;
    logic [7:0]  base_alpha;
  } result_t;

  typedef struct packed {
    logic [15:0]        contrast_gain;
    logic signed [17:0] brightness_offset;
    logic [15:0]        gamma_value;
    logic [7:0]         threshold_level;
    logic [7:0]         posterize_levels;
    logic [15:0]        mode_flags;
    logic [63:0]        fg_bg_colors;
    logic [63:0]        gradient_colors;
  } cfg_t;

  // Widths of the cell accumulators for a given largest pixel count.
  function automatic int cnt_w(input int max_px);
    return $clog2(max_px + 1);
  endfunction

  function automatic int luma_w(input int max_px);
    return $clog2(64'(max_px) * 64'd65535 + 64'd1);
  endfunction

  function automatic int chan_w(input int max_px);
    return $clog2(64'(max_px) * 64'd255 + 64'd1);
  endfunction

  function automatic int rec_w(input int max_px);
    return luma_w(max_px) + 3 * chan_w(max_px) + 8 + cnt_w(max_px);
  endfunction

  // Integer square root, one result bit per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bv;
    rem = x;
    res = 64'd0;
    bv  = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bv) begin
        rem = rem - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  // Q30 factors 2^(-2^(i-16)) for the exp2 product, entry i for fraction bit i.
  typedef logic [29:0] sq_tab_t [16];

  function automatic sq_tab_t build_sq_tab();
    sq_tab_t     t;
    logic [63:0] s;
    s = 64'd1 << 29;
    for (int i = 15; i >= 0; i--) begin
      s = isqrt64(s << 30);
      t[i] = s[29:0];
    end
    return t;
  endfunction

  localparam sq_tab_t SQ_TAB = build_sq_tab();

endpackage

// ----- rtl/acgs_queue.sv -----
module acgs_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // Pointers wrap at the depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- rtl/acgs_front.sv -----
module acgs_front #(
  parameter int MAX_CELL_PIXELS = acgs_pkg::MAX_CELL_PIXELS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          push,
  input  acgs_pkg::pixel_t                              pixel,
  input  logic                                          q_full,
  output logic                                          q_wr,
  output logic [acgs_pkg::rec_w(MAX_CELL_PIXELS)-1:0]   q_data
);

  import acgs_pkg::*;

  localparam int CNT_W  = cnt_w(MAX_CELL_PIXELS);
  localparam int LUMA_W = luma_w(MAX_CELL_PIXELS);
  localparam int CHAN_W = chan_w(MAX_CELL_PIXELS);

  logic [LUMA_W-1:0] luma_sum;
  logic [CHAN_W-1:0] red_sum;
  logic [CHAN_W-1:0] green_sum;
  logic [CHAN_W-1:0] blue_sum;
  logic [7:0]        alpha_peak;
  logic [CNT_W-1:0]  pixel_count;

  logic [LUMA_W-1:0] luma_sum_next;
  logic [CHAN_W-1:0] red_sum_next;
  logic [CHAN_W-1:0] green_sum_next;
  logic [CHAN_W-1:0] blue_sum_next;
  logic [7:0]        alpha_peak_next;
  logic [CNT_W-1:0]  pixel_count_next;

  logic [23:0] weighted;
  logic [32:0] scaled;
  logic [15:0] pixel_luma;
  logic        accept;
  logic        room;

  // Pixel luma: weighted sum times 257, upper half, range 0..65535.
  assign weighted = 24'(LUMA_KR * pixel.red) + 24'(LUMA_KG * pixel.green)
                  + 24'(LUMA_KB * pixel.blue);
  assign scaled     = {1'b0, weighted, 8'd0} + 33'(weighted);
  assign pixel_luma = scaled[31:16];

  assign accept = push && !q_full;
  assign room   = (pixel_count < CNT_W'(MAX_CELL_PIXELS));

  // Accumulate while the cell has room; overflow pixels are dropped.
  always_comb begin
    luma_sum_next    = luma_sum;
    red_sum_next     = red_sum;
    green_sum_next   = green_sum;
    blue_sum_next    = blue_sum;
    alpha_peak_next  = alpha_peak;
    pixel_count_next = pixel_count;
    if (room) begin
      luma_sum_next    = luma_sum + LUMA_W'(pixel_luma);
      red_sum_next     = red_sum + CHAN_W'(pixel.red);
      green_sum_next   = green_sum + CHAN_W'(pixel.green);
      blue_sum_next    = blue_sum + CHAN_W'(pixel.blue);
      alpha_peak_next  = (pixel.alpha > alpha_peak) ? pixel.alpha : alpha_peak;
      pixel_count_next = pixel_count + 1'b1;
    end
  end

  // A last-marked pixel hands the finished cell to the queue.
  assign q_wr   = accept && pixel.last_in_cell;
  assign q_data = {luma_sum_next, red_sum_next, green_sum_next, blue_sum_next,
                   alpha_peak_next, pixel_count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      luma_sum    <= '0;
      red_sum     <= '0;
      green_sum   <= '0;
      blue_sum    <= '0;
      alpha_peak  <= '0;
      pixel_count <= '0;
    end else if (accept) begin
      if (pixel.last_in_cell) begin
        luma_sum    <= '0;
        red_sum     <= '0;
        green_sum   <= '0;
        blue_sum    <= '0;
        alpha_peak  <= '0;
        pixel_count <= '0;
      end else begin
        luma_sum    <= luma_sum_next;
        red_sum     <= red_sum_next;
        green_sum   <= green_sum_next;
        blue_sum    <= blue_sum_next;
        alpha_peak  <= alpha_peak_next;
        pixel_count <= pixel_count_next;
      end
    end
  end

endmodule

// ----- rtl/acgs_div.sv -----
module acgs_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [STEP_W-1:0] steps;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  den_r;
  logic [DEN_W:0]    rem_sh;
  logic [DEN_W:0]    diff;
  logic              fits;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign rem_sh = {rem, quo[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign fits   = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(NUM_W);
      end
    end
  end

  // Datapath carries no reset.
  always_ff @(posedge clk) begin
    if (busy) begin
      rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo <= {quo[NUM_W-2:0], fits};
    end else if (start) begin
      rem   <= '0;
      den_r <= den;
      quo   <= num;
    end
  end

endmodule

// ----- rtl/acgs_back.sv -----
module acgs_back #(
  parameter int MAX_CELL_PIXELS = acgs_pkg::MAX_CELL_PIXELS_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  acgs_pkg::cfg_t                                cfg,
  input  logic                                          q_empty,
  input  logic [acgs_pkg::rec_w(MAX_CELL_PIXELS)-1:0]   q_data,
  output logic                                          q_rd,
  input  logic                                          pop,
  output logic                                          out_valid,
  output acgs_pkg::result_t                             result
);

  import acgs_pkg::*;

  localparam int CNT_W     = cnt_w(MAX_CELL_PIXELS);
  localparam int LUMA_W    = luma_w(MAX_CELL_PIXELS);
  localparam int CHAN_W    = chan_w(MAX_CELL_PIXELS);
  localparam int DIV_NUM_W = (LUMA_W + 1 > 33) ? LUMA_W + 1 : 33;
  localparam int DIV_DEN_W = (CNT_W > 16) ? CNT_W : 16;

  typedef enum logic [17:0] {
    S_IDLE = 18'b000000000000000001,
    S_DIV  = 18'b000000000000000010,
    S_CMUL = 18'b000000000000000100,
    S_CADJ = 18'b000000000000001000,
    S_GLOG = 18'b000000000000010000,
    S_GSQ  = 18'b000000000000100000,
    S_GNRM = 18'b000000000001000000,
    S_GDST = 18'b000000000010000000,
    S_GDIV = 18'b000000000100000000,
    S_GEM  = 18'b000000001000000000,
    S_GER  = 18'b000000010000000000,
    S_GFIN = 18'b000000100000000000,
    S_THR  = 18'b000001000000000000,
    S_POST = 18'b000010000000000000,
    S_PDIV = 18'b000100000000000000,
    S_INV  = 18'b001000000000000000,
    S_MIX  = 18'b010000000000000000,
    S_FIN  = 18'b100000000000000000
  } back_state_t;

  back_state_t state;

  // Cell record fields from the queue head.
  logic [LUMA_W-1:0] q_luma;
  logic [CHAN_W-1:0] q_red;
  logic [CHAN_W-1:0] q_green;
  logic [CHAN_W-1:0] q_blue;
  logic [7:0]        q_alpha;
  logic [CNT_W-1:0]  q_cnt;

  // Latched cell record.
  logic [CHAN_W-1:0] green_r;
  logic [CHAN_W-1:0] blue_r;
  logic [CHAN_W-1:0] red_r;
  logic [7:0]        alpha_r;
  logic [CNT_W-1:0]  cnt_r;

  // Working registers.
  logic [1:0]  div_sel;
  logic [15:0] avg;
  logic [7:0]  src_r;
  logic [7:0]  src_g;
  logic [7:0]  src_b;
  logic [16:0] v;
  logic [31:0] cprod;
  logic        cneg;
  logic [3:0]  k;
  logic [31:0] m;
  logic [61:0] sq;
  logic [3:0]  iter;
  logic [15:0] frac;
  logic [4:0]  e_ip;
  logic [15:0] e_f;
  logic [30:0] r;
  logic [60:0] rprod;
  logic [1:0]  ch;
  logic [7:0]  ink [4];

  // Divider interface.
  logic                 div_start;
  logic [DIV_NUM_W-1:0] div_num;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_NUM_W-1:0] div_quo;

  // Combinational helpers.
  logic [16:0]        d_full;
  logic [15:0]        d_abs;
  logic [32:0]        cround;
  logic [20:0]        cmag;
  logic signed [23:0] p_val;
  logic [16:0]        v_clamp;
  logic [3:0]         k_msb;
  logic [31:0]        m2;
  logic [20:0]        negv;
  logic [4:0]         sh;
  logic [31:0]        rsum;
  logic [31:0]        rshift;
  logic [24:0]        thr_lhs;
  logic [7:0]         post_l;
  logic [25:0]        post_p;
  logic [9:0]         post_n;
  logic [2:0]         mode;
  logic               keep;
  logic [31:0]        fg;
  logic [31:0]        bg;
  logic [31:0]        gs;
  logic [31:0]        ge;
  logic [7:0]         src_ch;
  logic [7:0]         gs_ch;
  logic [7:0]         ge_ch;
  logic signed [8:0]  mix_diff;
  logic signed [27:0] mix_sum;
  logic [7:0]         ink_ch;
  logic [16:0]        ord;
  logic [24:0]        gprod;
  logic [7:0]         base_alpha;

  assign {q_luma, q_red, q_green, q_blue, q_alpha, q_cnt} = q_data;

  assign mode = cfg.mode_flags[4:2];
  assign keep = cfg.mode_flags[5];
  assign fg   = cfg.fg_bg_colors[63:32];
  assign bg   = cfg.fg_bg_colors[31:0];
  assign gs   = cfg.gradient_colors[63:32];
  assign ge   = cfg.gradient_colors[31:0];

  acgs_div #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign q_rd = (state == S_IDLE) && !q_empty;

  // Contrast: distance from mid gray, scaled, rounded, offset and clamped.
  assign d_full = {1'b0, avg} - HALF_Q16;
  assign d_abs  = d_full[16] ? 16'(-d_full) : d_full[15:0];
  assign cround = {1'b0, cprod} + 33'd2048;
  assign cmag   = cround[32:12];
  assign p_val  = (cneg ? -$signed({3'b000, cmag}) : $signed({3'b000, cmag}))
                + $signed({7'd0, HALF_Q16}) + 24'(cfg.brightness_offset);
  assign v_clamp = (p_val < 0) ? 17'd0 :
                   (p_val > $signed({7'd0, ONE_Q16})) ? ONE_Q16 : p_val[16:0];

  // Leading one of the gamma input.
  always_comb begin
    k_msb = 4'd0;
    for (int i = 1; i < 16; i++) begin
      if (v[i]) begin
        k_msb = 4'(i);
      end
    end
  end

  // log2 and exp2 helpers.
  assign m2     = sq[61:30];
  assign negv   = {(5'd16 - {1'b0, k}), 16'd0} - 21'(frac);
  assign sh     = 5'd14 + e_ip;
  assign rsum   = {1'b0, r} + (32'd1 << (sh - 5'd1));
  assign rshift = rsum >> sh;

  // Threshold and posterize.
  assign thr_lhs = 25'(v * 8'd255);
  assign post_l  = cfg.posterize_levels - 8'd1;
  assign post_p  = 26'(v * post_l) + 26'd32768;
  assign post_n  = post_p[25:16];

  // Divider operand selection.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state)
      S_IDLE: begin
        div_start = !q_empty;
        div_num   = DIV_NUM_W'((LUMA_W + 1)'(q_luma) + (LUMA_W + 1)'(q_cnt >> 1));
        div_den   = DIV_DEN_W'(q_cnt);
      end
      S_DIV: begin
        div_start = div_done && (div_sel != 2'd3);
        div_den   = DIV_DEN_W'(cnt_r);
        unique case (div_sel)
          2'd0:    div_num = DIV_NUM_W'(red_r);
          2'd1:    div_num = DIV_NUM_W'(green_r);
          default: div_num = DIV_NUM_W'(blue_r);
        endcase
      end
      S_GDST: begin
        div_start = 1'b1;
        div_num   = DIV_NUM_W'({negv, 12'd0}) + DIV_NUM_W'(cfg.gamma_value >> 1);
        div_den   = DIV_DEN_W'(cfg.gamma_value);
      end
      S_POST: begin
        div_start = (cfg.posterize_levels > 8'd1);
        div_num   = DIV_NUM_W'({post_n, 16'd0}) + DIV_NUM_W'(post_l >> 1);
        div_den   = DIV_DEN_W'(post_l);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // Ink for the channel under work.
  always_comb begin
    unique case (ch)
      2'd0:    src_ch = src_r;
      2'd1:    src_ch = src_g;
      2'd2:    src_ch = src_b;
      default: src_ch = alpha_r;
    endcase
  end

  assign gs_ch    = gs[31 - 8 * ch -: 8];
  assign ge_ch    = ge[31 - 8 * ch -: 8];
  assign mix_diff = $signed({1'b0, ge_ch}) - $signed({1'b0, gs_ch});
  assign mix_sum  = $signed({4'd0, gs_ch, 16'd0})
                  + 28'(mix_diff * $signed({1'b0, v}))
                  + 28'sd32768;

  always_comb begin
    unique case (mode)
      MODE_SOURCE:   ink_ch = src_ch;
      MODE_TWO_TONE: ink_ch = (v < HALF_Q16) ? bg[31 - 8 * ch -: 8]
                                             : fg[31 - 8 * ch -: 8];
      MODE_GRADIENT: ink_ch = mix_sum[23:16];
      default:       ink_ch = fg[31 - 8 * ch -: 8];
    endcase
  end

  // Ramp index and base alpha.
  assign ord        = cfg.mode_flags[1] ? (ONE_Q16 - v) : v;
  assign gprod      = 25'(ord * cfg.mode_flags[15:8]) + 25'd32768;
  assign base_alpha = (mode == MODE_CUSTOM) ? bg[7:0] : (keep ? alpha_r : 8'd255);

  // Sequencer for one cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // The result register fills at the last step and drains on a pop.
      if (state == S_FIN && (!out_valid || pop)) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done && div_sel == 2'd3) begin
            state <= S_CMUL;
          end
        end
        S_CMUL: state <= S_CADJ;
        S_CADJ: begin
          if (cfg.gamma_value >= GAMMA_MIN && v_clamp != 17'd0 && !v_clamp[16]) begin
            state <= S_GLOG;
          end else begin
            state <= S_THR;
          end
        end
        S_GLOG: state <= S_GSQ;
        S_GSQ:  state <= S_GNRM;
        S_GNRM: state <= (iter == 4'd0) ? S_GDST : S_GSQ;
        S_GDST: state <= S_GDIV;
        S_GDIV: begin
          if (div_done) begin
            state <= (div_quo[DIV_NUM_W-1:16] > (DIV_NUM_W - 16)'(16)) ? S_THR : S_GEM;
          end
        end
        S_GEM:  state <= S_GER;
        S_GER:  state <= (iter == 4'd0) ? S_GFIN : S_GEM;
        S_GFIN: state <= S_THR;
        S_THR:  state <= S_POST;
        S_POST: state <= (cfg.posterize_levels > 8'd1) ? S_PDIV : S_INV;
        S_PDIV: begin
          if (div_done) begin
            state <= S_INV;
          end
        end
        S_INV: state <= S_MIX;
        S_MIX: begin
          if (ch == 2'd3) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || pop) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers follow the sequencer without reset.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        red_r   <= q_red;
        green_r <= q_green;
        blue_r  <= q_blue;
        alpha_r <= q_alpha;
        cnt_r   <= q_cnt;
        div_sel <= 2'd0;
      end
      S_DIV: begin
        if (div_done) begin
          unique case (div_sel)
            2'd0:    avg   <= div_quo[15:0];
            2'd1:    src_r <= div_quo[7:0];
            2'd2:    src_g <= div_quo[7:0];
            default: src_b <= div_quo[7:0];
          endcase
          div_sel <= div_sel + 2'd1;
        end
      end
      S_CMUL: begin
        cprod <= d_abs * cfg.contrast_gain;
        cneg  <= d_full[16];
      end
      S_CADJ: v <= v_clamp;
      S_GLOG: begin
        k    <= k_msb;
        m    <= 32'(v[15:0]) << (5'd30 - {1'b0, k_msb});
        iter <= 4'd15;
        frac <= 16'd0;
      end
      S_GSQ: sq <= m[30:0] * m[30:0];
      S_GNRM: begin
        if (m2[31]) begin
          m          <= m2 >> 1;
          frac[iter] <= 1'b1;
        end else begin
          m <= m2;
        end
        iter <= iter - 4'd1;
      end
      S_GDST: iter <= 4'd15;
      S_GDIV: begin
        if (div_done) begin
          if (div_quo[DIV_NUM_W-1:16] > (DIV_NUM_W - 16)'(16)) begin
            v <= 17'd0;
          end
          e_ip <= div_quo[20:16];
          e_f  <= div_quo[15:0];
          r    <= 31'h4000_0000;
        end
      end
      S_GEM: rprod <= r * SQ_TAB[iter];
      S_GER: begin
        if (e_f[iter]) begin
          r <= 31'((rprod + 61'h2000_0000) >> 30);
        end
        iter <= iter - 4'd1;
      end
      S_GFIN: v <= (rshift > 32'(ONE_Q16)) ? ONE_Q16 : rshift[16:0];
      S_THR: begin
        if (cfg.threshold_level != 8'd0) begin
          v <= (thr_lhs >= {1'b0, cfg.threshold_level, 16'd0}) ? ONE_Q16 : 17'd0;
        end
      end
      S_POST: ;
      S_PDIV: begin
        if (div_done) begin
          v <= div_quo[16:0];
        end
      end
      S_INV: begin
        if (cfg.mode_flags[0]) begin
          v <= ONE_Q16 - v;
        end
        ch <= 2'd0;
      end
      S_MIX: begin
        ink[ch] <= ink_ch;
        ch      <= ch + 2'd1;
      end
      S_FIN: begin
        if (!out_valid || pop) begin
          result.glyph_index   <= gprod[23:16];
          result.adjusted_luma <= v[16] ? 16'hFFFF : v[15:0];
          result.ink_red       <= ink[0];
          result.ink_green     <= ink[1];
          result.ink_blue      <= ink[2];
          result.ink_alpha     <= keep ? alpha_r : ink[3];
          result.base_red      <= (mode == MODE_CUSTOM) ? bg[31:24] : 8'd0;
          result.base_green    <= (mode == MODE_CUSTOM) ? bg[23:16] : 8'd0;
          result.base_blue     <= (mode == MODE_CUSTOM) ? bg[15:8] : 8'd0;
          result.base_alpha    <= base_alpha;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/ascii_cell_tone_glyph_select.sv -----
// Channel   Handshake            Payload
// pixel     push / full          pixel (red, green, blue, alpha, last_in_cell)
// result    empty / pop          result (glyph index, luma, ink, base)
// config    cfg_valid/cfg_ready  cfg_index, cfg_data
//
// The front takes one pixel every cycle while the cell queue has room.
// The back handles one cell at a time, its pace set by the shared
// one-bit-per-cycle divider (four averages, gamma and posterize divides)
// and the 16-step log2 and exp2 loops of the gamma unit.
// rst is synchronous: it clears the accumulators, the queue, the sequencer
// and the result valid flag, and loads the register reset values.
// A waiting result stalls the back only in its final step; the queue lets the
// front keep taking pixels meanwhile, and full rises when the queue fills.
module ascii_cell_tone_glyph_select #(
  parameter int MAX_CELL_PIXELS = acgs_pkg::MAX_CELL_PIXELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  acgs_pkg::pixel_t                    pixel,
  output logic                                empty,
  input  logic                                pop,
  output acgs_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [acgs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [acgs_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import acgs_pkg::*;

  localparam int REC_W = rec_w(MAX_CELL_PIXELS);

  cfg_t             cfg;
  logic             q_wr;
  logic [REC_W-1:0] q_wdata;
  logic             q_rd;
  logic [REC_W-1:0] q_rdata;
  logic             q_empty;
  logic             out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  // Configuration registers; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.contrast_gain     <= CONTRAST_RST;
      cfg.brightness_offset <= BRIGHTNESS_RST;
      cfg.gamma_value       <= GAMMA_RST;
      cfg.threshold_level   <= THRESHOLD_RST;
      cfg.posterize_levels  <= POSTERIZE_RST;
      cfg.mode_flags        <= MODE_RST;
      cfg.fg_bg_colors      <= FG_BG_RST;
      cfg.gradient_colors   <= GRADIENT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CONTRAST:   cfg.contrast_gain     <= cfg_data[15:0];
        REG_BRIGHTNESS: cfg.brightness_offset <= cfg_data[17:0];
        REG_GAMMA:      cfg.gamma_value       <= cfg_data[15:0];
        REG_THRESHOLD:  cfg.threshold_level   <= cfg_data[7:0];
        REG_POSTERIZE:  cfg.posterize_levels  <= cfg_data[7:0];
        REG_MODE:       cfg.mode_flags        <= cfg_data[15:0];
        REG_FG_BG:      cfg.fg_bg_colors      <= cfg_data;
        REG_GRADIENT:   cfg.gradient_colors   <= cfg_data;
        default:        ;
      endcase
    end
  end

  acgs_front #(
    .MAX_CELL_PIXELS (MAX_CELL_PIXELS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .pixel  (pixel),
    .q_full (full),
    .q_wr   (q_wr),
    .q_data (q_wdata)
  );

  acgs_queue #(
    .WIDTH (REC_W),
    .DEPTH (CELL_Q_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  acgs_back #(
    .MAX_CELL_PIXELS (MAX_CELL_PIXELS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .pop       (pop),
    .out_valid (out_valid),
    .result    (result)
  );

endmodule

// ----- rtl/acgs_checker.sv -----
`include "ascii_cell_tone_glyph_select_defines.svh"

module acgs_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            push,
  input logic                            full,
  input acgs_pkg::pixel_t                pixel,
  input logic                            empty,
  input logic                            pop,
  input acgs_pkg::result_t               result,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [acgs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [acgs_pkg::CFG_DATA_W-1:0] cfg_data
);

  import acgs_pkg::*;

  // Reset leaves no result pending and the cell queue open.
  `ACGS_ASSERT_NOW(a_reset_clean, $past(rst), empty && !full, "state after reset")

  // The queue can only fill through a transaction that closed a cell.
  `ACGS_ASSERT_NOW(a_full_source, $rose(full), $past(push && pixel.last_in_cell), "full without cell end")

  // A result that is not taken stays on the ports unchanged.
  `ACGS_ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result lost or changed")

endmodule

bind ascii_cell_tone_glyph_select acgs_checker u_acgs_checker (.*);
